@@ sv/gar_pkg.sv @@
// Shared types, constants and rounding helper for the gravity alignment block.
package gar_pkg;

	localparam int SW     = 16;
	localparam int FRAC   = 30;
	localparam int MW     = 34;
	localparam int PROD_W = 2 * MW;

	localparam logic [1:0] REG_CAL_X = 2'd0;
	localparam logic [1:0] REG_CAL_Y = 2'd1;
	localparam logic [1:0] REG_CAL_Z = 2'd2;

	localparam logic signed [MW-1:0] ONE_Q      = MW'(64'd1 << FRAC);
	localparam logic [MW-1:0]        NORM_FLOOR = MW'(64'd1 << 29);
	localparam logic [31:0]          NEAR_ZERO  = 32'd1074;

	typedef logic signed [MW-1:0] coef_t;

	typedef struct packed {
		logic signed [SW-1:0] data_x;
		logic signed [SW-1:0] data_y;
		logic signed [SW-1:0] data_z;
	} sample_t;

	typedef struct packed {
		logic signed [SW-1:0] out_x;
		logic signed [SW-1:0] out_y;
		logic signed [SW-1:0] out_z;
	} result_t;

	// Q8.60 product back to Q4.30, round half away from zero.
	function automatic coef_t rsh_q(input logic signed [PROD_W-1:0] v);
		logic [PROD_W-1:0] mg;
		logic [PROD_W-1:0] r;
		mg = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
		r  = (mg + (PROD_W'(1) << (FRAC - 1))) >> FRAC;
		return v[PROD_W-1] ? -coef_t'(r[MW-1:0]) : coef_t'(r[MW-1:0]);
	endfunction

endpackage

@@ sv/gravity_align_rotation.sv @@
// Top level: calibration sequencer plus four-stage matrix-apply pipeline.
// Rotates each sample by the matrix that maps the calibration vector onto +Z.
// One sample per cycle, registered in turn in d_s1, p_s2, sum_s3 and res_s4;
// the pipeline freezes as a whole while a result waits on result_ready. After a
// calibration write the shared multiply/sqrt/divide sequencer rebuilds the
// matrix, one square-root bit pair or quotient bit per cycle, and sample_ready
// stays low until it finishes.
module gravity_align_rotation (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_ready,
	input  gar_pkg::sample_t  sample,
	output logic              result_valid,
	input  logic              result_ready,
	output gar_pkg::result_t  result,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data
);
	import gar_pkg::*;

	localparam int PW    = MW + SW;
	localparam int SUM_W = PW + 2;
	localparam logic signed [SUM_W-1:0] HI = {{(SUM_W-SW+1){1'b0}}, {(SW-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] LO = {{(SUM_W-SW+1){1'b1}}, {(SW-1){1'b0}}};

	coef_t                   mat [3][3];
	logic                    busy;
	logic                    en;
	logic                    vld_s1, vld_s2, vld_s3, vld_s4;
	logic signed [SW-1:0]    d_s1 [3];
	logic signed [PW-1:0]    p_s2 [3][3];
	logic signed [SUM_W-1:0] sum_s3 [3];
	logic signed [SW-1:0]    res_s4 [3];
	logic signed [SW-1:0]    res_nx [3];

	gar_coef u_coef (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.busy      (busy),
		.mat       (mat)
	);

	assign en           = !vld_s4 || result_ready;
	assign sample_ready = en && !busy;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			logic [SUM_W-1:0]        mg;
			logic [SUM_W-1:0]        rq;
			logic signed [SUM_W-1:0] rsv;
			mg  = sum_s3[i][SUM_W-1] ? SUM_W'(-sum_s3[i]) : SUM_W'(sum_s3[i]);
			rq  = (mg + (SUM_W'(1) << (FRAC - 1))) >> FRAC;
			rsv = sum_s3[i][SUM_W-1] ? -$signed(rq) : $signed(rq);
			if (rsv > HI)
				res_nx[i] = HI[SW-1:0];
			else if (rsv < LO)
				res_nx[i] = LO[SW-1:0];
			else
				res_nx[i] = rsv[SW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= sample_valid && sample_ready;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1[0] <= sample.data_x;
			d_s1[1] <= sample.data_y;
			d_s1[2] <= sample.data_z;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++)
					p_s2[i][j] <= mat[i][j] * d_s1[j];
				sum_s3[i] <= SUM_W'(p_s2[i][0]) + SUM_W'(p_s2[i][1]) + SUM_W'(p_s2[i][2]);
				res_s4[i] <= res_nx[i];
			end
		end
	end

	assign result_valid = vld_s4;
	assign result.out_x = res_s4[0];
	assign result.out_y = res_s4[1];
	assign result.out_z = res_s4[2];

endmodule

@@ sv/gar_coef.sv @@
// Calibration registers and sequencer that builds the 3x3 rotation matrix.
module gar_coef (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	output logic               busy,
	output gar_pkg::coef_t     mat [3][3]
);
	import gar_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_LOAD, ST_NORM, ST_NSQ, ST_NSQRT, ST_FSET, ST_FDIV,
		ST_FSQ, ST_SSQRT, ST_KSET, ST_KDIV, ST_KMUL
	} state_t;

	state_t                state_q;
	logic                  ph_q;
	logic [2:0]            idx_q;
	logic [5:0]            cnt_q;
	logic signed [SW-1:0]  cal_q [3];
	logic signed [MW-1:0]  cs_q [3];
	logic [MW-1:0]         m_q;
	logic [63:0]           acc_q;
	logic [31:0]           den_q;
	logic [35:0]           rem_q;
	logic [63:0]           dq_q;
	logic [31:0]           root_q;
	logic                  neg_q;
	logic signed [MW-1:0]  f_q [3];
	logic [31:0]           s_q;
	logic signed [MW-1:0]  k_q [2];
	coef_t                 kxx_q, kxy_q, kyy_q;
	logic signed [PROD_W-1:0] prod_q;
	coef_t                 mat_q [3][3];

	logic signed [MW-1:0]  ma, mb, omc, xsel;
	logic [SW:0]           cm [3];
	logic [SW:0]           cmax;
	logic [35:0]           sq_rs, sq_trial, sq_rem;
	logic [31:0]           sq_root;
	logic [32:0]           dv_t, dv_rem;
	logic                  sq_ge, dv_ge;
	logic [63:0]           dv_dq;
	logic [MW-1:0]         xmag;
	logic [63:0]           num;
	logic signed [MW-1:0]  qres;
	coef_t                 rv;

	assign omc = ONE_Q - f_q[2];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cm[i] = {cal_q[i][SW-1], cal_q[i]};
			if (cal_q[i][SW-1])
				cm[i] = -cm[i];
		end
		cmax = cm[0];
		if (cm[1] > cmax)
			cmax = cm[1];
		if (cm[2] > cmax)
			cmax = cm[2];
	end

	always_comb begin
		ma = '0;
		mb = '0;
		unique case (state_q)
			ST_NSQ: begin
				ma = cs_q[idx_q[1:0]];
				mb = cs_q[idx_q[1:0]];
			end
			ST_FSQ: begin
				ma = f_q[idx_q[1:0]];
				mb = f_q[idx_q[1:0]];
			end
			ST_KMUL: begin
				unique case (idx_q)
					3'd0: begin ma = k_q[0]; mb = k_q[0]; end
					3'd1: begin ma = k_q[0]; mb = k_q[1]; end
					3'd2: begin ma = k_q[1]; mb = k_q[1]; end
					3'd3: begin ma = omc; mb = kxx_q; end
					3'd4: begin ma = omc; mb = kxy_q; end
					3'd5: begin ma = omc; mb = kyy_q; end
					3'd6: begin ma = {2'b00, s_q}; mb = k_q[1]; end
					3'd7: begin ma = {2'b00, s_q}; mb = k_q[0]; end
					default: begin ma = '0; mb = '0; end
				endcase
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	// one bit-pair of square root, one bit of division per cycle
	always_comb begin
		sq_rs    = {rem_q[33:0], dq_q[63:62]};
		sq_trial = {2'b00, root_q, 2'b01};
		sq_ge    = sq_rs >= sq_trial;
		sq_rem   = sq_ge ? sq_rs - sq_trial : sq_rs;
		sq_root  = {root_q[30:0], sq_ge};

		dv_t   = {rem_q[31:0], dq_q[63]};
		dv_ge  = dv_t >= {1'b0, den_q};
		dv_rem = dv_ge ? dv_t - {1'b0, den_q} : dv_t;
		dv_dq  = {dq_q[62:0], dv_ge};

		qres = neg_q ? -$signed(dv_dq[MW-1:0]) : $signed(dv_dq[MW-1:0]);
	end

	always_comb begin
		if (state_q == ST_KSET)
			xsel = idx_q[0] ? -f_q[0] : f_q[1];
		else
			xsel = cs_q[idx_q[1:0]];
		xmag = xsel[MW-1] ? MW'(-xsel) : MW'(xsel);
		num  = (64'(xmag) << FRAC) + 64'(den_q >> 1);
	end

	assign rv = rsh_q(prod_q);

	always_ff @(posedge clk)
		prod_q <= ma * mb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ph_q    <= 1'b0;
			idx_q   <= '0;
			cnt_q   <= '0;
			for (int i = 0; i < 3; i++) begin
				cal_q[i] <= '0;
				for (int j = 0; j < 3; j++)
					mat_q[i][j] <= (i == j) ? ONE_Q : '0;
			end
		end else if (cfg_we && (cfg_index == REG_CAL_X || cfg_index == REG_CAL_Y ||
				cfg_index == REG_CAL_Z)) begin
			unique case (cfg_index)
				REG_CAL_X: cal_q[0] <= cfg_data;
				REG_CAL_Y: cal_q[1] <= cfg_data;
				REG_CAL_Z: cal_q[2] <= cfg_data;
				default: ;
			endcase
			state_q <= ST_LOAD;
		end else begin
			unique case (state_q)
				ST_IDLE: ;
				ST_LOAD: begin
					for (int i = 0; i < 3; i++)
						cs_q[i] <= {{(MW-SW){cal_q[i][SW-1]}}, cal_q[i]};
					m_q <= MW'(cmax);
					if (cmax == '0) begin
						for (int i = 0; i < 3; i++)
							for (int j = 0; j < 3; j++)
								mat_q[i][j] <= (i == j) ? ONE_Q : '0;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_NORM;
					end
				end
				ST_NORM: begin
					if (m_q < NORM_FLOOR) begin
						m_q <= m_q << 1;
						for (int i = 0; i < 3; i++)
							cs_q[i] <= cs_q[i] <<< 1;
					end else begin
						state_q <= ST_NSQ;
						idx_q   <= '0;
						ph_q    <= 1'b0;
						acc_q   <= '0;
					end
				end
				ST_NSQ, ST_FSQ: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						acc_q <= acc_q + prod_q[63:0];
						idx_q <= idx_q + 3'd1;
						if ((state_q == ST_NSQ && idx_q == 3'd2) ||
								(state_q == ST_FSQ && idx_q == 3'd1)) begin
							dq_q    <= acc_q + prod_q[63:0];
							rem_q   <= '0;
							root_q  <= '0;
							cnt_q   <= '0;
							state_q <= (state_q == ST_NSQ) ? ST_NSQRT : ST_SSQRT;
						end
					end
				end
				ST_NSQRT, ST_SSQRT: begin
					rem_q  <= sq_rem;
					root_q <= sq_root;
					dq_q   <= dq_q << 2;
					cnt_q  <= cnt_q + 6'd1;
					if (cnt_q == 6'd31) begin
						idx_q <= '0;
						den_q <= sq_root;
						if (state_q == ST_NSQRT) begin
							state_q <= ST_FSET;
						end else begin
							s_q <= sq_root;
							if (sq_root < NEAR_ZERO) begin
								for (int i = 0; i < 3; i++)
									for (int j = 0; j < 3; j++)
										if (i != j)
											mat_q[i][j] <= '0;
										else if (i == 1 || f_q[2] > 0)
											mat_q[i][j] <= ONE_Q;
										else
											mat_q[i][j] <= -ONE_Q;
								state_q <= ST_IDLE;
							end else begin
								state_q <= ST_KSET;
							end
						end
					end
				end
				ST_FSET, ST_KSET: begin
					dq_q    <= num;
					rem_q   <= '0;
					neg_q   <= xsel[MW-1];
					cnt_q   <= '0;
					state_q <= (state_q == ST_FSET) ? ST_FDIV : ST_KDIV;
				end
				ST_FDIV, ST_KDIV: begin
					rem_q <= 36'(dv_rem);
					dq_q  <= dv_dq;
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) begin
						if (state_q == ST_FDIV) begin
							f_q[idx_q[1:0]] <= qres;
							if (idx_q == 3'd2) begin
								state_q <= ST_FSQ;
								idx_q   <= '0;
								ph_q    <= 1'b0;
								acc_q   <= '0;
							end else begin
								idx_q   <= idx_q + 3'd1;
								state_q <= ST_FSET;
							end
						end else begin
							k_q[idx_q[0]] <= qres;
							if (idx_q == 3'd1) begin
								state_q <= ST_KMUL;
								idx_q   <= '0;
								ph_q    <= 1'b0;
							end else begin
								idx_q   <= idx_q + 3'd1;
								state_q <= ST_KSET;
							end
						end
					end
				end
				ST_KMUL: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						idx_q <= idx_q + 3'd1;
						unique case (idx_q)
							3'd0: kxx_q <= rv;
							3'd1: kxy_q <= rv;
							3'd2: kyy_q <= rv;
							3'd3: mat_q[0][0] <= f_q[2] + rv;
							3'd4: begin
								mat_q[0][1] <= rv;
								mat_q[1][0] <= rv;
							end
							3'd5: mat_q[1][1] <= f_q[2] + rv;
							3'd6: begin
								mat_q[0][2] <= rv;
								mat_q[2][0] <= -rv;
							end
							3'd7: begin
								mat_q[1][2] <= -rv;
								mat_q[2][1] <= rv;
								mat_q[2][2] <= f_q[2];
								state_q     <= ST_IDLE;
							end
							default: ;
						endcase
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign mat  = mat_q;

endmodule
